### rtl/core/msf_pkg.sv
package msf_pkg;

	localparam int VelW   = 32;
	localparam int ArmW   = 18;
	localparam int ScaleW = 32;
	localparam int IdW    = 8;
	localparam int LinW   = 34;
	localparam int WheelW = 51;
	localparam int MagW   = 34;
	localparam int ProdW  = 64;
	localparam int HiW    = 34;
	localparam int IpW    = 35;
	localparam int SpdW   = 16;

	localparam int QDEPTH = 8;
	localparam int QAW    = 3;
	localparam int QCW    = 4;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_ARM_SUM        = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RPM_SCALE      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LEFT_FRONT_ID  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LEFT_REAR_ID   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RIGHT_FRONT_ID = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_RIGHT_REAR_ID  = 3'd5;

	localparam logic [ArmW-1:0]   ARM_SUM_RST   = 18'd19661;
	localparam logic [ScaleW-1:0] RPM_SCALE_RST = 32'd19660800;
	localparam logic [IdW-1:0]    LF_ID_RST     = 8'd1;
	localparam logic [IdW-1:0]    LR_ID_RST     = 8'd2;
	localparam logic [IdW-1:0]    RF_ID_RST     = 8'd3;
	localparam logic [IdW-1:0]    RR_ID_RST     = 8'd4;

	// 0.001 in Q16.16, moved up to the Q.32 wheel speed
	localparam logic signed [WheelW-1:0] DIR_THRESH = 51'sd4325376;

	localparam logic [7:0] BYTE_CMD_VEL = 8'hF6;
	localparam logic [7:0] BYTE_ACCEL   = 8'h00;
	localparam logic [7:0] BYTE_SYNC_EN = 8'h01;
	localparam logic [7:0] BYTE_TAIL    = 8'h6B;
	localparam logic [7:0] BYTE_SYNC_0  = 8'h00;
	localparam logic [7:0] BYTE_SYNC_1  = 8'hFF;
	localparam logic [7:0] BYTE_SYNC_2  = 8'h66;

	localparam logic [2:0] FRAME_SYNC    = 3'd4;
	localparam logic [2:0] POS_VEL_END   = 3'd7;
	localparam logic [2:0] POS_SYNC_END  = 3'd3;
	localparam logic [5:0] RUN_LAST_IDX  = 6'd35;

	localparam logic [2:0] POS_ID    = 3'd0;
	localparam logic [2:0] POS_CMD   = 3'd1;
	localparam logic [2:0] POS_DIR   = 3'd2;
	localparam logic [2:0] POS_SPD_H = 3'd3;
	localparam logic [2:0] POS_SPD_L = 3'd4;
	localparam logic [2:0] POS_ACCEL = 3'd5;
	localparam logic [2:0] POS_SYNC  = 3'd6;

	typedef struct packed {
		logic            dir;
		logic [SpdW-1:0] speed;
	} wheel_rec_t;

	typedef struct packed {
		logic                 push;
		wheel_rec_t           rec;
	} q_wr_t;

	typedef struct packed {
		logic [ArmW-1:0]       arm_sum;
		logic [ScaleW-1:0]     rpm_scale;
		logic [3:0][IdW-1:0]   ids;
	} cfg_t;

endpackage

### rtl/core/msf_front.sv
module msf_front import msf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic signed [VelW-1:0] vel_x,
	input  logic signed [VelW-1:0] vel_y,
	input  logic signed [VelW-1:0] vel_spin,
	input  cfg_t                   cfg,
	input  logic                   q_pop,
	output q_wr_t                  q_wr
);

	logic                   hold_valid_q;
	logic signed [VelW-1:0] vx_q, vy_q, spin_q;
	logic [1:0]             widx_q;
	logic [QCW-1:0]         used_q;

	logic issue, last_issue, accept;

	assign issue      = hold_valid_q && (used_q < QCW'(QDEPTH));
	assign last_issue = issue && (widx_q == 2'd3);
	assign full       = hold_valid_q && !last_issue;
	assign accept     = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			widx_q       <= 2'd0;
			used_q       <= '0;
		end else begin
			if (accept) begin
				hold_valid_q <= 1'b1;
			end else if (last_issue) begin
				hold_valid_q <= 1'b0;
			end
			if (accept) begin
				widx_q <= 2'd0;
			end else if (issue) begin
				widx_q <= widx_q + 2'd1;
			end
			// credit covers records in flight and records waiting in the queue
			case ({issue, q_pop})
				2'b10:   used_q <= used_q + QCW'(1);
				2'b01:   used_q <= used_q - QCW'(1);
				default: used_q <= used_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q   <= vel_x;
			vy_q   <= vel_y;
			spin_q <= vel_spin;
		end
	end

	// stage 1: linear term and arm product
	logic signed [LinW-1:0]   vx_e, vy_e, lin_c;
	logic signed [WheelW-1:0] rot_c;

	assign vx_e  = LinW'(vx_q);
	assign vy_e  = LinW'(vy_q);
	assign lin_c = (widx_q[0] ^ widx_q[1]) ? (vy_e - vx_e) : (vy_e + vx_e);
	assign rot_c = $signed({1'b0, cfg.arm_sum}) * spin_q;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [LinW-1:0]   lin_s1;
	logic signed [WheelW-1:0] rot_s1;
	logic [1:0]               widx_s1, widx_s2;

	// stage 2: wheel speed in Q.32
	logic signed [WheelW-1:0] shifted_c, w_c, w_s2;

	assign shifted_c = $signed({lin_s1[LinW-1], lin_s1, 16'b0});
	assign w_c       = widx_s1[1] ? (shifted_c - rot_s1) : (shifted_c + rot_s1);

	// stage 3: direction and Q16.16 magnitude
	logic [WheelW-1:0] mag_c;
	logic              below_c;
	logic [MagW-1:0]   m_s3;
	logic              neg_s3, dir_s3, front_s3;

	assign mag_c   = w_s2[WheelW-1] ? WheelW'(-w_s2) : WheelW'(w_s2);
	assign below_c = (w_s2 < DIR_THRESH);

	// stage 4: scale to rpm, split so no product exceeds 32 by 32
	logic [ProdW-1:0] plo_c, plo_s4;
	logic [HiW-1:0]   phi_c, phi_s4;
	logic             neg_s4, dir_s4, front_s4;

	assign plo_c = ProdW'(m_s3[31:0]) * ProdW'(cfg.rpm_scale);
	assign phi_c = HiW'(m_s3[MagW-1:32]) * HiW'(cfg.rpm_scale);

	// stage 5: integer rpm
	logic [IpW-1:0] ip_s5;
	logic           lowz_s5, neg_s5, dir_s5, front_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		lin_s1   <= lin_c;
		rot_s1   <= rot_c;
		widx_s1  <= widx_q;
		w_s2     <= w_c;
		widx_s2  <= widx_s1;
		m_s3     <= mag_c[MagW+15:16];
		neg_s3   <= w_s2[WheelW-1];
		dir_s3   <= widx_s2[1] ? !below_c : below_c;
		front_s3 <= !widx_s2[0];
		plo_s4   <= plo_c;
		phi_s4   <= phi_c;
		neg_s4   <= neg_s3;
		dir_s4   <= dir_s3;
		front_s4 <= front_s3;
		ip_s5    <= IpW'(plo_s4[ProdW-1:32]) + IpW'(phi_s4);
		lowz_s5  <= (plo_s4[31:0] == 32'd0);
		neg_s5   <= neg_s4;
		dir_s5   <= dir_s4;
		front_s5 <= front_s4;
	end

	// front wheels take two off the signed rpm before the magnitude
	logic [IpW:0]    r_c;
	logic [SpdW-1:0] speed_c;

	always_comb begin
		if (!front_s5) begin
			r_c = {1'b0, ip_s5};
		end else if (neg_s5) begin
			r_c = {1'b0, ip_s5} + (IpW+1)'(2);
		end else if (ip_s5 >= IpW'(2)) begin
			r_c = {1'b0, ip_s5} - (IpW+1)'(2);
		end else if (ip_s5 == '0) begin
			r_c = lowz_s5 ? (IpW+1)'(2) : (IpW+1)'(1);
		end else begin
			r_c = lowz_s5 ? (IpW+1)'(1) : (IpW+1)'(0);
		end
		speed_c = (r_c > (IpW+1)'(65535)) ? {SpdW{1'b1}} : r_c[SpdW-1:0];
	end

	assign q_wr.push      = v_s5;
	assign q_wr.rec.dir   = dir_s5;
	assign q_wr.rec.speed = speed_c;

endmodule

### rtl/core/msf_queue.sv
module msf_queue import msf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_wr_t      q_wr,
	input  logic       q_pop,
	output wheel_rec_t head,
	output logic       avail
);

	wheel_rec_t     mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({q_wr.push, q_pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.rec;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign avail = (cnt_q != '0);

endmodule

### rtl/core/msf_back.sv
module msf_back import msf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  wheel_rec_t head,
	input  logic       avail,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] tx_byte,
	output logic       frame_end,
	output logic       last
);

	logic [5:0] idx_q;
	logic [2:0] frame, pos;
	logic       is_sync, can_gen, load;
	logic [7:0] byte_c;
	logic       end_c, last_c;

	logic       out_valid_q;
	logic [7:0] tx_byte_q;
	logic       frame_end_q, last_q;

	assign frame   = idx_q[5:3];
	assign pos     = idx_q[2:0];
	assign is_sync = (frame == FRAME_SYNC);
	// a velocity frame waits for its wheel record; the sync frame needs none
	assign can_gen = is_sync || avail;
	assign load    = can_gen && (!out_valid_q || pop);
	assign q_pop   = load && !is_sync && (pos == POS_VEL_END);

	always_comb begin
		if (is_sync) begin
			case (pos)
				3'd0:    byte_c = BYTE_SYNC_0;
				3'd1:    byte_c = BYTE_SYNC_1;
				3'd2:    byte_c = BYTE_SYNC_2;
				default: byte_c = BYTE_TAIL;
			endcase
		end else begin
			case (pos)
				POS_ID:    byte_c = cfg.ids[frame[1:0]];
				POS_CMD:   byte_c = BYTE_CMD_VEL;
				POS_DIR:   byte_c = {7'd0, head.dir};
				POS_SPD_H: byte_c = head.speed[15:8];
				POS_SPD_L: byte_c = head.speed[7:0];
				POS_ACCEL: byte_c = BYTE_ACCEL;
				POS_SYNC:  byte_c = BYTE_SYNC_EN;
				default:   byte_c = BYTE_TAIL;
			endcase
		end
		end_c  = is_sync ? (pos == POS_SYNC_END) : (pos == POS_VEL_END);
		last_c = is_sync && (pos == POS_SYNC_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= (idx_q == RUN_LAST_IDX) ? 6'd0 : idx_q + 6'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte_q   <= byte_c;
			frame_end_q <= end_c;
			last_q      <= last_c;
		end
	end

	assign empty     = !out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign frame_end = frame_end_q;
	assign last      = last_q;

endmodule

### rtl/core/mecanum_speed_command_framer.sv
// Channel   Direction  Handshake             Payload
// command   in         push / full           vel_x, vel_y, vel_spin (Q16.16, signed)
// stream    out        empty / pop           tx_byte, frame_end, last
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every command gives 36 stream bytes, one per cycle at most; the byte serialiser
// sets the sustained rate of commands.
// The wheel pipeline works one wheel per cycle while the queue has room, five stages
// deep.
// A queue of eight wheel records (two commands) parts the wheel pipeline from
// the serialiser, so pop held low stalls only the serialiser at first.
// Reset returns the configuration registers to their defaults and empties all.
module mecanum_speed_command_framer import msf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic signed [VelW-1:0] vel_x,
	input  logic signed [VelW-1:0] vel_y,
	input  logic signed [VelW-1:0] vel_spin,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             tx_byte,
	output logic                   frame_end,
	output logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgDataW-1:0]    cfg_data
);

	logic [ArmW-1:0]   arm_sum_q;
	logic [ScaleW-1:0] rpm_scale_q;
	logic [IdW-1:0]    lf_id_q, lr_id_q, rf_id_q, rr_id_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_sum_q   <= ARM_SUM_RST;
			rpm_scale_q <= RPM_SCALE_RST;
			lf_id_q     <= LF_ID_RST;
			lr_id_q     <= LR_ID_RST;
			rf_id_q     <= RF_ID_RST;
			rr_id_q     <= RR_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ARM_SUM:        arm_sum_q   <= cfg_data[ArmW-1:0];
				REG_RPM_SCALE:      rpm_scale_q <= cfg_data[ScaleW-1:0];
				REG_LEFT_FRONT_ID:  lf_id_q     <= cfg_data[IdW-1:0];
				REG_LEFT_REAR_ID:   lr_id_q     <= cfg_data[IdW-1:0];
				REG_RIGHT_FRONT_ID: rf_id_q     <= cfg_data[IdW-1:0];
				REG_RIGHT_REAR_ID:  rr_id_q     <= cfg_data[IdW-1:0];
				default: ;
			endcase
		end
	end

	cfg_t cfg;

	assign cfg.arm_sum   = arm_sum_q;
	assign cfg.rpm_scale = rpm_scale_q;
	assign cfg.ids[0]    = lf_id_q;
	assign cfg.ids[1]    = lr_id_q;
	assign cfg.ids[2]    = rf_id_q;
	assign cfg.ids[3]    = rr_id_q;

	q_wr_t      q_wr;
	wheel_rec_t head;
	logic       avail, q_pop;

	msf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.vel_x    (vel_x),
		.vel_y    (vel_y),
		.vel_spin (vel_spin),
		.cfg      (cfg),
		.q_pop    (q_pop),
		.q_wr     (q_wr)
	);

	msf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_pop  (q_pop),
		.head   (head),
		.avail  (avail)
	);

	msf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.avail     (avail),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.tx_byte   (tx_byte),
		.frame_end (frame_end),
		.last      (last)
	);

endmodule

### rtl/core/msf_checker.sv
module msf_checker import msf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] tx_byte,
	input logic       frame_end,
	input logic       last
);

	// nothing waits on the stream once reset has been seen
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("stream not empty after reset");

	// every frame closes on the tail byte
	a_end_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> (tx_byte == BYTE_TAIL))
		else $error("frame end without tail byte");

	// the run ends on the end of a frame
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> frame_end)
		else $error("last byte outside a frame end");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(tx_byte)))
		else $error("stalled stream byte changed");

endmodule

bind mecanum_speed_command_framer msf_checker u_msf_checker (.*);
